// ----- src/ftmp_pkg.sv -----
// Shared types, constants and lookup functions for the framed text message parser.
// No dependencies; every other file of the block imports this package.
package ftmp_pkg;

   localparam int unsigned NUM_KEYWORDS = 9;
   localparam int unsigned KW_CHARS     = 13;

   localparam logic [2:0] PREFIX_LEN      = 3'd7;
   localparam logic [7:0] FIELD_SEP       = 8'h7C;
   localparam logic [1:0] MAX_FIELD_INDEX = 2'd3;

   localparam logic [1:0] FIELD_TYPE    = 2'd0;
   localparam logic [1:0] FIELD_SESSION = 2'd1;
   localparam logic [1:0] FIELD_ROLE    = 2'd2;

   localparam logic       KIND_CONTENT = 1'b0;
   localparam logic       KIND_SUMMARY = 1'b1;

   localparam logic [1:0] TAG_SESSION = 2'd0;
   localparam logic [1:0] TAG_ROLE    = 2'd1;
   localparam logic [1:0] TAG_PAYLOAD = 2'd2;

   localparam logic [3:0] TYPE_UNKNOWN    = 4'd0;
   localparam logic [3:0] TYPE_PLAIN_TEXT = 4'd1;

   // Keyword text, right-aligned in the vector; first character is the most significant.
   localparam logic [8*KW_CHARS-1:0] KW_TEXT [NUM_KEYWORDS] = '{
      104'h6173725F74657874,
      104'h7074745F646F776E,
      104'h7074745F7570,
      104'h7474735F74657874,
      104'h7474735F656E64,
      104'h7474735F696E74657272757074,
      104'h706C61795F656E64,
      104'h6C6C6D5F61636B,
      104'h6C6C6D5F61626F7274
   };
   localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
      4'd8, 4'd8, 4'd6, 4'd8, 4'd7, 4'd13, 4'd8, 4'd7, 4'd9
   };

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] out_byte;
      logic [1:0] field_tag;
      logic [3:0] message_type;
      logic       framed;
      logic       session_default;
      logic       role_default;
      logic       last_of_run;
   } rsp_type;

   // One classified input beat: a prefix replay, an optional byte and an optional summary.
   typedef struct packed {
      logic [2:0] replay_count;
      logic       byte_valid;
      logic [7:0] byte_value;
      logic [1:0] byte_tag;
      logic [3:0] byte_type;
      logic       byte_framed;
      logic       sum_valid;
      logic [3:0] sum_type;
      logic       sum_framed;
      logic       sum_session_default;
      logic       sum_role_default;
   } cmd_type;

   // Frame prefix characters, in order.
   function automatic logic [7:0] prefix_char(logic [2:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0:    c = 8'h43;
         3'd1:    c = 8'h41;
         3'd2:    c = 8'h42;
         3'd3:    c = 8'h49;
         3'd4:    c = 8'h4E;
         3'd5:    c = 8'h31;
         3'd6:    c = FIELD_SEP;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] kw_char(int unsigned k, logic [3:0] pos);
      logic [8*KW_CHARS-1:0] text;
      logic [3:0]            len;
      int                    base;
      text = KW_TEXT[k];
      len  = KW_LEN[k];
      base = 8 * (int'(len) - 1 - int'(pos));
      if (pos < len) begin
         return text[base +: 8];
      end
      return 8'h00;
   endfunction

endpackage

// ----- src/ftmp_front.sv -----
// Front end: accepts message bytes, tracks prefix, field and keyword state,
// and issues one command per beat that causes results. Uses ftmp_pkg.
module ftmp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  ftmp_pkg::req_type req,
   output logic              cmd_push,
   output ftmp_pkg::cmd_type cmd
);
   import ftmp_pkg::*;

   typedef enum logic [1:0] {
      PH_PREFIX,
      PH_BODY,
      PH_RAW
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [2:0] prefix_pos_ff, prefix_pos_in;
   logic [1:0] field_ff, field_in;
   logic [3:0] name_pos_ff, name_pos_in;
   logic [NUM_KEYWORDS-1:0] hits_ff, hits_in;
   logic [3:0] type_ff, type_in;
   logic       session_seen_ff, session_seen_in;
   logic       role_seen_ff, role_seen_in;

   logic [7:0] lower;
   logic [2:0] pos_inc;

   function automatic logic [3:0] resolve_type(logic [NUM_KEYWORDS-1:0] hits,
                                               logic [3:0] pos);
      logic [3:0] code;
      code = TYPE_UNKNOWN;
      for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
         if (hits[k] && KW_LEN[k] == pos) begin
            code = 4'(k + 1);
         end
      end
      return code;
   endfunction

   always_comb begin
      lower = req.data_byte;
      if (req.data_byte inside {[8'h41:8'h5A]}) begin
         lower = req.data_byte + 8'd32;
      end
      pos_inc = prefix_pos_ff + 3'd1;

      phase_in        = phase_ff;
      prefix_pos_in   = prefix_pos_ff;
      field_in        = field_ff;
      name_pos_in     = name_pos_ff;
      hits_in         = hits_ff;
      type_in         = type_ff;
      session_seen_in = session_seen_ff;
      role_seen_in    = role_seen_ff;

      cmd             = '0;
      cmd.byte_value  = req.data_byte;
      cmd.byte_tag    = TAG_PAYLOAD;
      cmd.byte_type   = TYPE_PLAIN_TEXT;

      case (phase_ff)
         PH_PREFIX: begin
            if (req.data_byte == prefix_char(prefix_pos_ff)) begin
               prefix_pos_in = pos_inc;
               if (pos_inc == PREFIX_LEN) begin
                  phase_in = PH_BODY;
               end else if (req.end_of_message) begin
                  cmd.replay_count = pos_inc;
                  phase_in         = PH_RAW;
               end
            end else begin
               cmd.replay_count = prefix_pos_ff;
               cmd.byte_valid   = 1'b1;
               phase_in         = PH_RAW;
            end
         end
         PH_BODY: begin
            if (req.data_byte == FIELD_SEP && field_ff != MAX_FIELD_INDEX) begin
               if (field_ff == FIELD_TYPE) begin
                  type_in = resolve_type(hits_ff, name_pos_ff);
               end
               field_in = field_ff + 2'd1;
            end else if (field_ff == FIELD_TYPE) begin
               for (int k = 0; k < NUM_KEYWORDS; k++) begin
                  hits_in[k] = hits_ff[k] && name_pos_ff < KW_LEN[k]
                               && kw_char(k, name_pos_ff) == lower;
               end
               if (name_pos_ff != 4'd15) begin
                  name_pos_in = name_pos_ff + 4'd1;
               end
            end else begin
               cmd.byte_valid  = 1'b1;
               cmd.byte_type   = type_ff;
               cmd.byte_framed = 1'b1;
               if (field_ff == FIELD_SESSION) begin
                  session_seen_in = 1'b1;
                  cmd.byte_tag    = TAG_SESSION;
               end else if (field_ff == FIELD_ROLE) begin
                  role_seen_in = 1'b1;
                  cmd.byte_tag = TAG_ROLE;
               end
            end
         end
         default: begin
            cmd.byte_valid = 1'b1;
         end
      endcase

      if (req.end_of_message) begin
         cmd.sum_valid = 1'b1;
         if (phase_in == PH_BODY) begin
            cmd.sum_type = (field_in == FIELD_TYPE) ? resolve_type(hits_in, name_pos_in)
                                                    : type_in;
            cmd.sum_framed          = 1'b1;
            cmd.sum_session_default = !session_seen_in;
            cmd.sum_role_default    = !role_seen_in;
         end else begin
            cmd.sum_type            = TYPE_PLAIN_TEXT;
            cmd.sum_session_default = 1'b1;
            cmd.sum_role_default    = 1'b1;
         end
         // The message is over: return to the state after reset.
         phase_in        = PH_PREFIX;
         prefix_pos_in   = '0;
         field_in        = FIELD_TYPE;
         name_pos_in     = '0;
         hits_in         = '1;
         type_in         = TYPE_UNKNOWN;
         session_seen_in = 1'b0;
         role_seen_in    = 1'b0;
      end

      cmd_push = accept && (cmd.replay_count != 3'd0 || cmd.byte_valid || cmd.sum_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_PREFIX;
         prefix_pos_ff   <= '0;
         field_ff        <= FIELD_TYPE;
         name_pos_ff     <= '0;
         hits_ff         <= '1;
         type_ff         <= TYPE_UNKNOWN;
         session_seen_ff <= 1'b0;
         role_seen_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         prefix_pos_ff   <= prefix_pos_in;
         field_ff        <= field_in;
         name_pos_ff     <= name_pos_in;
         hits_ff         <= hits_in;
         type_ff         <= type_in;
         session_seen_ff <= session_seen_in;
         role_seen_ff    <= role_seen_in;
      end
   end

endmodule

// ----- src/ftmp_queue.sv -----
// Short command queue between the front and back ends of the parser.
// Uses ftmp_pkg for the command type.
module ftmp_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ftmp_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output ftmp_pkg::cmd_type head_cmd,
   output logic              empty
);
   import ftmp_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   cmd_type           entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              do_push, do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ----- src/ftmp_back.sv -----
// Back end: expands each queued command into result beats, one per cycle while
// they are taken, through a registered output stage. Uses ftmp_pkg.
module ftmp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_empty,
   input  ftmp_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output ftmp_pkg::rsp_type rsp_payload
);
   import ftmp_pkg::*;

   logic [2:0] step_ff, step_in;
   logic       valid_ff;
   rsp_type    rsp_ff, rsp_in;
   logic       advance;
   logic       is_last;

   assign advance     = !cmd_empty && (!valid_ff || rsp_pop);
   assign rsp_empty   = !valid_ff;
   assign rsp_payload = rsp_ff;
   assign cmd_pop     = advance && is_last;

   always_comb begin
      rsp_in              = '0;
      rsp_in.kind         = KIND_CONTENT;
      rsp_in.field_tag    = TAG_PAYLOAD;
      rsp_in.message_type = TYPE_PLAIN_TEXT;
      is_last             = 1'b0;
      step_in             = step_ff + 3'd1;

      if (step_ff < cmd.replay_count) begin
         rsp_in.out_byte = prefix_char(step_ff);
         is_last = (step_in == cmd.replay_count) && !cmd.byte_valid && !cmd.sum_valid;
      end else if (step_ff == cmd.replay_count && cmd.byte_valid) begin
         rsp_in.out_byte     = cmd.byte_value;
         rsp_in.field_tag    = cmd.byte_tag;
         rsp_in.message_type = cmd.byte_type;
         rsp_in.framed       = cmd.byte_framed;
         is_last             = !cmd.sum_valid;
      end else begin
         rsp_in.kind            = KIND_SUMMARY;
         rsp_in.field_tag       = TAG_SESSION;
         rsp_in.message_type    = cmd.sum_type;
         rsp_in.framed          = cmd.sum_framed;
         rsp_in.session_default = cmd.sum_session_default;
         rsp_in.role_default    = cmd.sum_role_default;
         is_last                = 1'b1;
      end
      rsp_in.last_of_run = is_last;
      if (is_last) begin
         step_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            step_ff  <= step_in;
            valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ----- src/framed_text_message_parser.sv -----
// Framed text message parser. Message bytes enter one per beat; the front end
// classifies each byte in the cycle it is accepted and queues a command, and the
// back end turns each command into result beats through an output register, one per
// cycle while taken. Most bytes cause at most one result, so the block sustains one
// byte per cycle; a failed or truncated frame prefix replays up to six held bytes,
// and the final byte adds a summary beat, so such a byte yields up to eight result
// beats. The command queue (QUEUE_DEPTH entries) lets the input keep flowing while
// those bursts drain. There is no configuration and no clearing pass after reset.
module framed_text_message_parser #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  ftmp_pkg::req_type req_payload,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output ftmp_pkg::rsp_type rsp_payload
);
   import ftmp_pkg::*;

   cmd_type front_cmd, head_cmd;
   logic    front_push, queue_empty, back_pop, accept;

   assign accept = req_push && !req_full;

   ftmp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_payload),
      .cmd_push (front_push),
      .cmd      (front_cmd)
   );

   ftmp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_push),
      .push_cmd (front_cmd),
      .full     (req_full),
      .pop      (back_pop),
      .head_cmd (head_cmd),
      .empty    (queue_empty)
   );

   ftmp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_empty   (queue_empty),
      .cmd         (head_cmd),
      .cmd_pop     (back_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- src/ftmp_checker.sv -----
// Port-level checks for the framed text message parser, bound to the top level.
// Uses ftmp_pkg for the payload types.
module ftmp_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input ftmp_pkg::rsp_type rsp_payload
);
   import ftmp_pkg::*;

   // A result beat not taken stays on the ports unchanged.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_payload))
      else $error("result beat changed before it was taken");

   // A summary always closes the run of results for its byte.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_payload.kind == KIND_SUMMARY |-> rsp_payload.last_of_run)
      else $error("summary beat not marked last of run");

   // Content beats never carry default flags.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_payload.kind == KIND_CONTENT
      |-> !rsp_payload.session_default && !rsp_payload.role_default)
      else $error("content beat carries a default flag");

   // Unframed results are always of the plain text type.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_payload.framed |-> rsp_payload.message_type == TYPE_PLAIN_TEXT)
      else $error("unframed result with wrong message type");

   assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result present straight after reset");

endmodule

bind framed_text_message_parser ftmp_checker u_ftmp_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_empty   (rsp_empty),
   .rsp_pop     (rsp_pop),
   .rsp_payload (rsp_payload)
);
